// ===== rtl/vfc_pkg.sv =====
`timescale 1ns / 1ps
package vfc_pkg;

   localparam int CHUNK_X_DEF = 16;
   localparam int CHUNK_Y_DEF = 64;
   localparam int CHUNK_Z_DEF = 16;

   localparam int OPCODE_W = 2;
   localparam int COORD_W = 4;
   localparam int Y_W = 6;
   localparam int HEIGHT_W = 7;
   localparam int DIR_W = 3;
   localparam int VERT_W = 20;
   localparam int NUM_DIRS = 6;
   localparam logic [VERT_W-1:0] VERTS_PER_FACE = VERT_W'(4);

   localparam logic [OPCODE_W-1:0] OP_SET   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PLACE = 2'd2;

   localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
   localparam logic [DIR_W-1:0] DIR_NX = 3'd1;
   localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
   localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
   localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
   localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

   typedef struct packed {
      logic             take;
      logic             clear_step;
      logic             issue;
      logic [DIR_W-1:0] dir;
      logic             emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic place_ok;
      logic clear_done;
      logic faces_left;
      logic last_pick;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== rtl/vfc_req_if.sv =====
`timescale 1ns / 1ps
interface vfc_req_if import vfc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [COORD_W-1:0]  pos_x;
   logic [Y_W-1:0]      pos_y;
   logic [COORD_W-1:0]  pos_z;
   logic [HEIGHT_W-1:0] column_height;

   modport source (output valid, opcode, pos_x, pos_y, pos_z, column_height, input ready);
   modport sink (input valid, opcode, pos_x, pos_y, pos_z, column_height, output ready);
endinterface

// ===== rtl/vfc_rsp_if.sv =====
`timescale 1ns / 1ps
interface vfc_rsp_if import vfc_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] face_x;
   logic [Y_W-1:0]     face_y;
   logic [COORD_W-1:0] face_z;
   logic [DIR_W-1:0]   face_dir;
   logic [VERT_W-1:0]  base_vertex;
   logic               last_face;

   modport source (output valid, face_x, face_y, face_z, face_dir, base_vertex, last_face,
                   input ready);
   modport sink (input valid, face_x, face_y, face_z, face_dir, base_vertex, last_face,
                 output ready);
endinterface

// ===== rtl/vfc_ctrl.sv =====
`timescale 1ns / 1ps
module vfc_ctrl import vfc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_LOOK  = 5'b00100,
      S_DRAIN = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [DIR_W-1:0] dir_ff, dir_in;

   always_comb begin
      state_in = state_ff;
      dir_in = dir_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.take = req_valid;
            dir_in = DIR_PX;
            if (req_valid && stat.place_ok) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.issue = 1'b1;
            cmd.dir = dir_ff;
            dir_in = dir_ff + DIR_W'(1);
            if (dir_ff == DIR_NZ) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = stat.faces_left && stat.out_free;
            if (!stat.faces_left || (cmd.emit && stat.last_pick)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         dir_ff <= DIR_PX;
      end else begin
         state_ff <= state_in;
         dir_ff <= dir_in;
      end
   end

endmodule

// ===== rtl/vfc_datapath.sv =====
`timescale 1ns / 1ps
module vfc_datapath import vfc_pkg::*; #(
   parameter int CHUNK_X = CHUNK_X_DEF,
   parameter int CHUNK_Y = CHUNK_Y_DEF,
   parameter int CHUNK_Z = CHUNK_Z_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [OPCODE_W-1:0] opcode,
   input  logic [COORD_W-1:0]  pos_x,
   input  logic [Y_W-1:0]      pos_y,
   input  logic [COORD_W-1:0]  pos_z,
   input  logic [HEIGHT_W-1:0] column_height,
   input  ctrl_cmd_type        cmd,
   output dp_stat_type         stat,
   vfc_rsp_if.source           rsp
);

   localparam int DEPTH = CHUNK_X * CHUNK_Z;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [HEIGHT_W-1:0] heights_mem [DEPTH];
   logic [HEIGHT_W-1:0] rd_height_ff;
   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;

   logic [COORD_W-1:0]  x_ff, z_ff;
   logic [Y_W-1:0]      y_ff;
   logic [VERT_W-1:0]   count_ff, count_in;
   logic [NUM_DIRS-1:0] mask_ff, mask_in;

   logic                lk_vld_ff;
   logic [DIR_W-1:0]    lk_dir_ff;
   logic                lk_edge_ff;
   logic [Y_W:0]        lk_y_ff;

   logic                out_vld_ff, out_vld_in;
   logic [COORD_W-1:0]  out_x_ff, out_z_ff;
   logic [Y_W-1:0]      out_y_ff;
   logic [DIR_W-1:0]    out_dir_ff;
   logic [VERT_W-1:0]   out_base_ff;
   logic                out_last_ff;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [HEIGHT_W-1:0] wr_data, sat_height;
   logic                col_ok;
   logic [COORD_W:0]    nx, nz;
   logic [Y_W:0]        ny;
   logic                nb_edge, exposed;
   logic [DIR_W-1:0]    pick;
   logic [NUM_DIRS-1:0] remain;

   // column write: sweep on reset, else set request
   always_comb begin
      col_ok = (32'(pos_x) < CHUNK_X) && (32'(pos_z) < CHUNK_Z);
      sat_height = (32'(column_height) > CHUNK_Y) ? HEIGHT_W'(CHUNK_Y) : column_height;
      wr_en = cmd.clear_step || (cmd.take && opcode == OP_SET && col_ok);
      wr_addr = cmd.clear_step ? clr_cnt_ff
                               : ADDR_W'(32'(pos_x) * CHUNK_Z + 32'(pos_z));
      wr_data = cmd.clear_step ? '0 : sat_height;
      clr_cnt_in = cmd.clear_step ? clr_cnt_ff + ADDR_W'(1) : clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heights_mem[wr_addr] <= wr_data;
      end
      rd_height_ff <= heights_mem[rd_addr];
   end

   // neighbor of the held voxel
   always_comb begin
      nx = {1'b0, x_ff};
      ny = {1'b0, y_ff};
      nz = {1'b0, z_ff};
      nb_edge = 1'b0;
      case (cmd.dir)
         DIR_PX: begin
            nx = {1'b0, x_ff} + (COORD_W+1)'(1);
            nb_edge = 32'(nx) >= CHUNK_X;
         end
         DIR_NX: begin
            nx = {1'b0, x_ff} - (COORD_W+1)'(1);
            nb_edge = x_ff == '0;
         end
         DIR_PY: begin
            ny = {1'b0, y_ff} + (Y_W+1)'(1);
            nb_edge = 32'(ny) >= CHUNK_Y;
         end
         DIR_NY: begin
            ny = {1'b0, y_ff} - (Y_W+1)'(1);
            nb_edge = y_ff == '0;
         end
         DIR_PZ: begin
            nz = {1'b0, z_ff} + (COORD_W+1)'(1);
            nb_edge = 32'(nz) >= CHUNK_Z;
         end
         DIR_NZ: begin
            nz = {1'b0, z_ff} - (COORD_W+1)'(1);
            nb_edge = z_ff == '0;
         end
         default: begin
            nb_edge = 1'b1;
         end
      endcase
      rd_addr = ADDR_W'(32'(nx) * CHUNK_Z + 32'(nz));
   end

   always_comb begin
      exposed = lk_edge_ff || !((lk_y_ff == '0) || (lk_y_ff < {1'b0, rd_height_ff[Y_W-1:0]})
                                || rd_height_ff[HEIGHT_W-1]);
      pick = DIR_NZ;
      for (int i = NUM_DIRS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick = DIR_W'(i);
         end
      end
      remain = mask_ff;
      remain[pick] = 1'b0;

      mask_in = mask_ff;
      if (cmd.take) begin
         mask_in = '0;
      end else if (lk_vld_ff && exposed) begin
         mask_in[lk_dir_ff] = 1'b1;
      end else if (cmd.emit) begin
         mask_in = remain;
      end

      count_in = count_ff;
      if (cmd.take && opcode == OP_CLEAR) begin
         count_in = '0;
      end else if (cmd.emit) begin
         count_in = count_ff + VERTS_PER_FACE;
      end

      out_vld_in = out_vld_ff && !rsp.ready;
      if (cmd.emit) begin
         out_vld_in = 1'b1;
      end

      stat.place_ok = (opcode == OP_PLACE) && col_ok && (32'(pos_y) < CHUNK_Y);
      stat.clear_done = clr_cnt_ff == ADDR_W'(DEPTH - 1);
      stat.faces_left = |mask_ff;
      stat.last_pick = remain == '0;
      stat.out_free = !out_vld_ff || rsp.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         count_ff <= '0;
         mask_ff <= '0;
         lk_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         count_ff <= count_in;
         mask_ff <= mask_in;
         lk_vld_ff <= cmd.issue;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         x_ff <= pos_x;
         y_ff <= pos_y;
         z_ff <= pos_z;
      end
      lk_dir_ff <= cmd.dir;
      lk_edge_ff <= nb_edge;
      lk_y_ff <= ny;
      if (cmd.emit) begin
         out_x_ff <= x_ff;
         out_y_ff <= y_ff;
         out_z_ff <= z_ff;
         out_dir_ff <= pick;
         out_base_ff <= count_ff;
         out_last_ff <= remain == '0;
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.face_x = out_x_ff;
   assign rsp.face_y = out_y_ff;
   assign rsp.face_z = out_z_ff;
   assign rsp.face_dir = out_dir_ff;
   assign rsp.base_vertex = out_base_ff;
   assign rsp.last_face = out_last_ff;

endmodule

// ===== rtl/voxel_face_culling_mesher.sv =====
`timescale 1ns / 1ps
// Face-culling mesher for one chunk held as a column height map.
// req channel: one request per handshake; opcode set column height, clear
//   vertex count or place voxel. Set and clear are taken without leaving idle.
// rsp channel: one face record per handshake, in the order +x, -x, +y, -y,
//   +z, -z, last_face marking the final record of a place request.
// A place makes six lookups, one per side, through the one read port of the
//   height memory, one per cycle, then walks the exposed-side mask, loading
//   one face a cycle into the output register while that register is free;
//   req ready is high again in the cycle after the last face is loaded.
// Reset clears the height memory in a pass over all CHUNK_X*CHUNK_Z columns
//   (256 at the default size), during which req ready stays low; the vertex
//   count clears at once.
// When the receiver stalls the face stays in the output register and the
//   face walk holds; a new request is taken once the last face of a place is
//   registered, even while it still waits on rsp.
module voxel_face_culling_mesher import vfc_pkg::*; #(
   parameter int CHUNK_X = CHUNK_X_DEF,
   parameter int CHUNK_Y = CHUNK_Y_DEF,
   parameter int CHUNK_Z = CHUNK_Z_DEF
) (
   input logic       clock,
   input logic       reset,
   vfc_req_if.sink   req,
   vfc_rsp_if.source rsp
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   vfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vfc_datapath #(
      .CHUNK_X (CHUNK_X),
      .CHUNK_Y (CHUNK_Y),
      .CHUNK_Z (CHUNK_Z)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .opcode        (req.opcode),
      .pos_x         (req.pos_x),
      .pos_y         (req.pos_y),
      .pos_z         (req.pos_z),
      .column_height (req.column_height),
      .cmd           (cmd),
      .stat          (stat),
      .rsp           (rsp)
   );

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("face loaded over a waiting face");

   a_no_take_in_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req.ready)
      else $error("request taken during neighbor lookup");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.last_pick) |=> req.ready)
      else $error("no return to idle after last face");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.clear_step, cmd.issue, cmd.emit}))
      else $error("conflicting datapath commands");

endmodule

// ===== dv/voxel_face_culling_mesher_test.sv =====
`timescale 1ns / 1ps
import vfc_pkg::*;

typedef struct packed {
   logic [OPCODE_W-1:0] opcode;
   logic [COORD_W-1:0]  pos_x;
   logic [Y_W-1:0]      pos_y;
   logic [COORD_W-1:0]  pos_z;
   logic [HEIGHT_W-1:0] column_height;
} voxel_req_type;

typedef struct packed {
   logic [COORD_W-1:0] face_x;
   logic [Y_W-1:0]     face_y;
   logic [COORD_W-1:0] face_z;
   logic [DIR_W-1:0]   face_dir;
   logic [VERT_W-1:0]  base_vertex;
   logic               last_face;
} face_rec_type;

class culled_mesh;
   logic [HEIGHT_W-1:0] heights [CHUNK_X_DEF*CHUNK_Z_DEF];
   logic [VERT_W-1:0]   vertex_count;
   face_rec_type        pending_faces [$];
   int                  errors;
   int                  reported;
   int                  requests;
   int                  faces_checked;
   int                  silent_places;
   int                  wraps;

   function new();
      foreach (heights[i]) heights[i] = '0;
      vertex_count = '0;
      errors = 0;
      reported = 0;
      requests = 0;
      faces_checked = 0;
      silent_places = 0;
      wraps = 0;
   endfunction

   function bit solid_voxel(int x, int y, int z);
      if (x < 0 || x >= CHUNK_X_DEF || y < 0 || y >= CHUNK_Y_DEF ||
          z < 0 || z >= CHUNK_Z_DEF)
         return 1'b0;
      if (y == 0)
         return 1'b1;
      return y < int'(heights[x*CHUNK_Z_DEF + z]);
   endfunction

   function void take_request(voxel_req_type r);
      face_rec_type     faces [$];
      face_rec_type     f;
      logic [DIR_W-1:0] dir;
      logic [VERT_W-1:0] prev;
      int               nx;
      int               ny;
      int               nz;
      requests++;
      case (r.opcode)
         OP_SET: begin
            if (int'(r.pos_x) < CHUNK_X_DEF && int'(r.pos_z) < CHUNK_Z_DEF)
               heights[int'(r.pos_x)*CHUNK_Z_DEF + int'(r.pos_z)] =
                  (int'(r.column_height) > CHUNK_Y_DEF) ? HEIGHT_W'(CHUNK_Y_DEF)
                                                        : r.column_height;
         end
         OP_CLEAR: vertex_count = '0;
         OP_PLACE: begin
            if (int'(r.pos_x) < CHUNK_X_DEF && int'(r.pos_y) < CHUNK_Y_DEF &&
                int'(r.pos_z) < CHUNK_Z_DEF) begin
               for (int d = 0; d < NUM_DIRS; d++) begin
                  dir = DIR_W'(d);
                  nx = int'(r.pos_x);
                  ny = int'(r.pos_y);
                  nz = int'(r.pos_z);
                  case (dir)
                     DIR_PX: nx++;
                     DIR_NX: nx--;
                     DIR_PY: ny++;
                     DIR_NY: ny--;
                     DIR_PZ: nz++;
                     DIR_NZ: nz--;
                     default: ;
                  endcase
                  if (!solid_voxel(nx, ny, nz)) begin
                     f.face_x = r.pos_x;
                     f.face_y = r.pos_y;
                     f.face_z = r.pos_z;
                     f.face_dir = dir;
                     f.base_vertex = vertex_count;
                     f.last_face = 1'b0;
                     faces = {faces, f};
                     prev = vertex_count;
                     vertex_count = vertex_count + VERTS_PER_FACE;
                     if (vertex_count < prev)
                        wraps++;
                  end
               end
               if (faces.size() > 0)
                  faces[faces.size()-1].last_face = 1'b1;
               else
                  silent_places++;
               pending_faces = {pending_faces, faces};
            end
         end
         default: ;
      endcase
   endfunction

   function void match_face(face_rec_type got);
      face_rec_type want;
      if (pending_faces.size() == 0) begin
         errors++;
         if (reported < 10) begin
            reported++;
            $display("unexpected face: x=%0d y=%0d z=%0d dir=%0d base=%0d last=%0d",
                     got.face_x, got.face_y, got.face_z, got.face_dir,
                     got.base_vertex, got.last_face);
         end
         return;
      end
      want = pending_faces.pop_front();
      faces_checked++;
      if (got !== want) begin
         errors++;
         if (reported < 10) begin
            reported++;
            $display("face mismatch: expected x=%0d y=%0d z=%0d dir=%0d base=%0d last=%0d",
                     want.face_x, want.face_y, want.face_z, want.face_dir,
                     want.base_vertex, want.last_face);
            $display("               got      x=%0d y=%0d z=%0d dir=%0d base=%0d last=%0d",
                     got.face_x, got.face_y, got.face_z, got.face_dir,
                     got.base_vertex, got.last_face);
         end
      end
   endfunction
endclass

module voxel_face_culling_mesher_test;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PER_PHASE = 70;
   localparam int OPEN_PLACES = 20;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   int   hold_len = 0;
   int   hold_go = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   culled_mesh   sb;
   face_rec_type seen_face;

   vfc_req_if req_bus ();
   vfc_rsp_if rsp_bus ();

   voxel_face_culling_mesher dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen = hold_go;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen_face.face_x = rsp_bus.face_x;
         seen_face.face_y = rsp_bus.face_y;
         seen_face.face_z = rsp_bus.face_z;
         seen_face.face_dir = rsp_bus.face_dir;
         seen_face.base_vertex = rsp_bus.base_vertex;
         seen_face.last_face = rsp_bus.last_face;
         sb.match_face(seen_face);
      end
   end

   function automatic voxel_req_type mk(logic [OPCODE_W-1:0] op, int x, int y, int z, int h);
      voxel_req_type r;
      r.opcode = op;
      r.pos_x = COORD_W'(x);
      r.pos_y = Y_W'(y);
      r.pos_z = COORD_W'(z);
      r.column_height = HEIGHT_W'(h);
      return r;
   endfunction

   function automatic voxel_req_type random_request();
      voxel_req_type r;
      int pick;
      int y;
      r.pos_x = ($urandom_range(1) == 1) ? COORD_W'($urandom_range(0, 3))
                                         : COORD_W'($urandom_range(0, 15));
      r.pos_z = ($urandom_range(1) == 1) ? COORD_W'($urandom_range(0, 3))
                                         : COORD_W'($urandom_range(0, 15));
      r.pos_y = Y_W'($urandom_range(0, 63));
      r.column_height = HEIGHT_W'($urandom_range(0, 127));
      pick = $urandom_range(99);
      if (pick < 35) begin
         r.opcode = OP_SET;
         if ($urandom_range(3) != 0)
            r.column_height = HEIGHT_W'($urandom_range(0, 24));
      end else if (pick < 88) begin
         r.opcode = OP_PLACE;
         // aim near the column top where exposure changes
         if ($urandom_range(9) < 7) begin
            y = int'(sb.heights[int'(r.pos_x)*CHUNK_Z_DEF + int'(r.pos_z)]) +
                int'($urandom_range(0, 4)) - 2;
            if (y < 0)
               y = 0;
            if (y > 63)
               y = 63;
            r.pos_y = Y_W'(y);
         end
      end else if (pick < 94) begin
         r.opcode = OP_CLEAR;
      end else begin
         r.opcode = OP_UNUSED;
      end
      return r;
   endfunction

   task automatic send_req(voxel_req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.opcode = r.opcode;
      req_bus.pos_x = r.pos_x;
      req_bus.pos_y = r.pos_y;
      req_bus.pos_z = r.pos_z;
      req_bus.column_height = r.column_height;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.take_request(r);
      @(negedge clock);
   endtask

   task automatic wait_for_faces();
      req_bus.valid = 1'b0;
      while (sb.pending_faces.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(int req_pct, int rsp_pct);
      @(posedge clock);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      @(negedge clock);
   endtask

   task automatic hold_receiver(int cycles);
      @(posedge clock);
      hold_len = cycles;
      hold_go++;
      @(negedge clock);
   endtask

   task automatic random_burst(int count);
      repeat (count) send_req(random_request());
   endtask

   initial begin
      voxel_req_type r;
      sb = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_SET;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.column_height = '0;
      rsp_bus.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_idling(24, 75);
      send_req(mk(OP_PLACE, 0, 0, 0, 0));
      send_req(mk(OP_PLACE, 15, 63, 15, 0));
      send_req(mk(OP_UNUSED, 15, 63, 15, 127));
      send_req(mk(OP_SET, 5, 7, 127, 127));
      send_req(mk(OP_SET, 4, 7, 0, 64));
      send_req(mk(OP_SET, 6, 7, 0, 63));
      send_req(mk(OP_SET, 5, 8, 0, 64));
      send_req(mk(OP_SET, 5, 6, 0, 64));
      send_req(mk(OP_PLACE, 5, 10, 7, 0));
      send_req(mk(OP_PLACE, 5, 62, 7, 0));
      send_req(mk(OP_PLACE, 5, 63, 7, 0));
      send_req(mk(OP_PLACE, 5, 0, 7, 127));
      send_req(mk(OP_CLEAR, 0, 0, 0, 0));
      send_req(mk(OP_PLACE, 6, 63, 7, 0));
      send_req(mk(OP_SET, 15, 15, 0, 100));
      send_req(mk(OP_PLACE, 15, 62, 15, 0));
      send_req(mk(OP_PLACE, 15, 63, 15, 0));
      send_req(mk(OP_PLACE, 7, 0, 7, 0));
      send_req(mk(OP_UNUSED, 0, 0, 0, 0));
      send_req(mk(OP_SET, 6, 7, 0, 0));
      send_req(mk(OP_PLACE, 6, 1, 7, 0));
      send_req(mk(OP_CLEAR, 15, 63, 15, 127));
      send_req(mk(OP_PLACE, 0, 63, 0, 0));
      wait_for_faces();

      // stall the receiver while places keep arriving
      hold_receiver(400);
      repeat (12) begin
         r = random_request();
         r.opcode = OP_PLACE;
         send_req(r);
      end
      wait_for_faces();

      random_burst(RANDOM_PER_PHASE);
      wait_for_faces();

      set_idling(75, 24);
      random_burst(RANDOM_PER_PHASE);
      wait_for_faces();

      set_idling(0, 0);
      random_burst(RANDOM_PER_PHASE);
      wait_for_faces();

      // place voxels with all six sides exposed, back to back
      send_req(mk(OP_CLEAR, 0, 0, 0, 0));
      send_req(mk(OP_SET, 8, 0, 8, 0));
      send_req(mk(OP_SET, 9, 0, 8, 0));
      send_req(mk(OP_SET, 7, 0, 8, 0));
      send_req(mk(OP_SET, 8, 0, 9, 0));
      send_req(mk(OP_SET, 8, 0, 7, 0));
      repeat (OPEN_PLACES) send_req(mk(OP_PLACE, 8, $urandom_range(2, 63), 8, 0));
      wait_for_faces();

      if (sb.pending_faces.size() != 0) begin
         $display("%0d expected faces never arrived", sb.pending_faces.size());
         sb.errors++;
      end
      $display("covered %0d requests, %0d faces checked, %0d places with no exposed side",
               sb.requests, sb.faces_checked, sb.silent_places);
      $display("vertex count wrapped %0d time(s); %0d failures", sb.wraps, sb.errors);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
